### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define TPMP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds across reset
`define TPMP_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPMP_ASSERT(name, prop, msg)
`define TPMP_ASSERT_RST(name, prop, msg)
`endif

`endif

### hdl/tpmp_pkg.sv
// ----------------------------------------------------------------------------
// tpmp_pkg
// Types and constants of the timed pad macro player.
// ----------------------------------------------------------------------------
`default_nettype none

package tpmp_pkg;

  localparam int MAX_STEPS = 16;
  localparam int IDX_W     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);

  localparam logic [23:0] ELAPSED_MAX = 24'hFFFFFF;
  localparam logic [7:0]  TRIG_FULL   = 8'hFF;

  typedef enum logic [2:0] {
    CMD_WRITE  = 3'd0,
    CMD_START  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_TOGGLE = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    REG_REPEAT_MODE = 2'd0,
    REG_TOTAL_MS    = 2'd1,
    REG_CYCLE_MS    = 2'd2,
    REG_STEP_COUNT  = 2'd3
  } cfg_reg_t;

  localparam logic [1:0] MODE_ONCE  = 2'd0;
  localparam logic [1:0] MODE_TIMED = 2'd1;
  localparam logic [1:0] MODE_LOOP  = 2'd2;
  // spare encoding, plays as loop
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  step_index;
    logic [15:0] step_start;
    logic [15:0] step_end;
    logic [15:0] step_hold;
    logic [15:0] effect_buttons;
    logic [1:0]  effect_stick_flags;
    logic [63:0] effect_sticks;
    logic [13:0] pad_buttons;
    logic [15:0] pad_triggers;
    logic [63:0] pad_sticks;
  } in_item_t;

  typedef struct packed {
    logic [13:0] out_buttons;
    logic [15:0] out_triggers;
    logic [63:0] out_sticks;
    logic        playing;
  } out_item_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] stop;
    logic [15:0] hold;
    logic [15:0] buttons;
    logic [1:0]  stick_flags;
    logic [63:0] sticks;
  } step_entry_t;

endpackage

`default_nettype wire

### hdl/tpmp_ram.sv
// ----------------------------------------------------------------------------
// tpmp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tpmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hdl/timed_pad_macro_player_top.sv
// ----------------------------------------------------------------------------
// timed_pad_macro_player_top
// Plays a timed step table over a live gamepad state, one tick per ms.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats are taken when start is high and busy is low. cmd selects
//   write step, start, stop, toggle or tick. Only a tick beat returns a
//   result: out_strobe is high for one cycle with the merged pad on
//   out_item. The receiver cannot stall; every result must be taken.
//   Config writes (cfg_we, cfg_addr, cfg_wdata) land at once and stop
//   playback; issue them only while idle.
// Timing:
//   Non-tick beats never raise busy. A tick that is not playing (inactive,
//   disabled or ending) gives its result in the next cycle. A playing tick
//   scans the step RAM one entry per cycle through its single read port
//   until a slot matches or the last entry is read, at most
//   min(step_count, MAX_STEPS) entries; busy stays high while it scans.
// Reset:
//   rst_n (synchronous) clears playback state and config; the step table
//   holds nothing valid until written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module timed_pad_macro_player_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire tpmp_pkg::in_item_t   in_item,
  output logic                      out_strobe,
  output tpmp_pkg::out_item_t       out_item,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_addr,
  input  wire logic [23:0]          cfg_wdata
);

  localparam int IDX_W = tpmp_pkg::IDX_W;
  localparam int CNT_W = tpmp_pkg::CNT_W;

  tpmp_pkg::state_t    state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                active_r, active_nxt;
  logic [23:0]         elapsed_r, elapsed_nxt;
  logic [15:0]         pos_r, pos_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  tpmp_pkg::out_item_t out_item_r, out_item_nxt;

  logic [1:0]          repeat_mode_r;
  logic [23:0]         total_ms_r;
  logic [15:0]         cycle_ms_r;
  logic [4:0]          step_count_r;

  logic [13:0]         pad_buttons_r;
  logic [15:0]         pad_triggers_r;
  logic [63:0]         pad_sticks_r;

  logic                in_acc;
  logic                is_tick;
  logic                enabled;
  logic                stop_now;
  logic                go_scan;
  logic                tick_pass;
  logic [CNT_W-1:0]    n_steps;
  logic                scan_last;
  logic                slot_hit;
  logic                hold_hit;
  logic                scan_done;
  logic                scan_end;
  logic [23:0]         elapsed_inc;
  logic [16:0]         pos_inc;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [IDX_W-1:0]    ram_raddr;
  tpmp_pkg::step_entry_t ram_wdata;
  tpmp_pkg::step_entry_t ram_rdata;
  tpmp_pkg::out_item_t   merged;

  // ---- step table ----
  tpmp_ram #(
    .WIDTH ($bits(tpmp_pkg::step_entry_t)),
    .DEPTH (tpmp_pkg::MAX_STEPS)
  ) u_step_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy    = (state_r != tpmp_pkg::ST_IDLE);
  assign in_acc  = start && !busy;
  assign is_tick = (in_item.cmd == tpmp_pkg::CMD_TICK);

  assign ram_we    = in_acc && (in_item.cmd == tpmp_pkg::CMD_WRITE) &&
                     (32'(in_item.step_index) < tpmp_pkg::MAX_STEPS);
  assign ram_waddr = IDX_W'(32'(in_item.step_index));
  assign ram_wdata = '{start:       in_item.step_start,
                       stop:        in_item.step_end,
                       hold:        in_item.step_hold,
                       buttons:     in_item.effect_buttons,
                       stick_flags: in_item.effect_stick_flags,
                       sticks:      in_item.effect_sticks};
  assign ram_raddr = (state_r == tpmp_pkg::ST_SCAN) ? idx_r + IDX_W'(1) : '0;

  always_comb begin
    if (32'(step_count_r) > tpmp_pkg::MAX_STEPS) begin
      n_steps = CNT_W'(tpmp_pkg::MAX_STEPS);
    end else begin
      n_steps = CNT_W'(step_count_r);
    end
  end

  assign enabled  = (cycle_ms_r != 16'd0) && (step_count_r != 5'd0);
  assign stop_now = ((repeat_mode_r == tpmp_pkg::MODE_ONCE) &&
                     (elapsed_r >= 24'(cycle_ms_r))) ||
                    ((repeat_mode_r == tpmp_pkg::MODE_TIMED) &&
                     (elapsed_r >= total_ms_r));
  assign go_scan   = active_r && enabled && !stop_now;
  assign tick_pass = (state_r == tpmp_pkg::ST_IDLE) && in_acc && is_tick && !go_scan;

  // ---- slot match on the entry now on the read port ----
  assign scan_last = (32'(idx_r) + 32'd1) >= 32'(n_steps);
  assign slot_hit  = (pos_r >= ram_rdata.start) && (pos_r < ram_rdata.stop);
  assign hold_hit  = ({1'b0, pos_r} < ({1'b0, ram_rdata.start} + {1'b0, ram_rdata.hold}));
  assign scan_done = slot_hit || scan_last;
  assign scan_end  = (state_r == tpmp_pkg::ST_SCAN) && scan_done;

  assign elapsed_inc = (elapsed_r < tpmp_pkg::ELAPSED_MAX) ? elapsed_r + 24'd1 : elapsed_r;
  assign pos_inc     = {1'b0, pos_r} + 17'd1;

  // ---- merge ----
  always_comb begin
    merged.out_buttons  = pad_buttons_r;
    merged.out_triggers = pad_triggers_r;
    merged.out_sticks   = pad_sticks_r;
    merged.playing      = 1'b1;
    if (slot_hit && hold_hit) begin
      merged.out_buttons = pad_buttons_r |
                           {ram_rdata.buttons[15:8], ram_rdata.buttons[5:0]};
      if (ram_rdata.buttons[6]) begin
        merged.out_triggers[7:0] = tpmp_pkg::TRIG_FULL;
      end
      if (ram_rdata.buttons[7]) begin
        merged.out_triggers[15:8] = tpmp_pkg::TRIG_FULL;
      end
      if (ram_rdata.stick_flags[0]) begin
        merged.out_sticks[31:0] = ram_rdata.sticks[31:0];
      end
      if (ram_rdata.stick_flags[1]) begin
        merged.out_sticks[63:32] = ram_rdata.sticks[63:32];
      end
    end
  end

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tpmp_pkg::ST_IDLE: begin
        if (in_acc && is_tick && go_scan) begin
          state_nxt = tpmp_pkg::ST_SCAN;
        end
      end
      tpmp_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = tpmp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tpmp_pkg::ST_IDLE;
    endcase
  end

  // ---- outputs and datapath ----
  always_comb begin
    idx_nxt        = idx_r;
    active_nxt     = active_r;
    elapsed_nxt    = elapsed_r;
    pos_nxt        = pos_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    unique case (state_r)
      tpmp_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (tpmp_pkg::cmd_t'(in_item.cmd))
            tpmp_pkg::CMD_START: begin
              active_nxt  = 1'b1;
              elapsed_nxt = '0;
              pos_nxt     = '0;
            end
            tpmp_pkg::CMD_STOP: begin
              active_nxt = 1'b0;
            end
            tpmp_pkg::CMD_TOGGLE: begin
              if (active_r) begin
                active_nxt = 1'b0;
              end else begin
                active_nxt  = 1'b1;
                elapsed_nxt = '0;
                pos_nxt     = '0;
              end
            end
            tpmp_pkg::CMD_TICK: begin
              if (go_scan) begin
                idx_nxt = '0;
              end else begin
                out_strobe_nxt            = 1'b1;
                out_item_nxt.out_buttons  = in_item.pad_buttons;
                out_item_nxt.out_triggers = in_item.pad_triggers;
                out_item_nxt.out_sticks   = in_item.pad_sticks;
                out_item_nxt.playing      = 1'b0;
                if (active_r && !enabled) begin
                  elapsed_nxt = elapsed_inc;
                end else if (active_r) begin
                  active_nxt = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      tpmp_pkg::ST_SCAN: begin
        if (scan_done) begin
          out_strobe_nxt = 1'b1;
          out_item_nxt   = merged;
          if (elapsed_r < tpmp_pkg::ELAPSED_MAX) begin
            elapsed_nxt = elapsed_inc;
            pos_nxt     = (pos_inc == {1'b0, cycle_ms_r}) ? 16'd0 : pos_inc[15:0];
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: ;
    endcase
    if (cfg_we) begin
      active_nxt = 1'b0;
    end
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tpmp_pkg::ST_IDLE;
      idx_r         <= '0;
      active_r      <= 1'b0;
      elapsed_r     <= '0;
      pos_r         <= '0;
      out_strobe_r  <= 1'b0;
      repeat_mode_r <= '0;
      total_ms_r    <= '0;
      cycle_ms_r    <= '0;
      step_count_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      active_r     <= active_nxt;
      elapsed_r    <= elapsed_nxt;
      pos_r        <= pos_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        unique case (tpmp_pkg::cfg_reg_t'(cfg_addr))
          tpmp_pkg::REG_REPEAT_MODE: repeat_mode_r <= cfg_wdata[1:0];
          tpmp_pkg::REG_TOTAL_MS:    total_ms_r    <= cfg_wdata;
          tpmp_pkg::REG_CYCLE_MS:    cycle_ms_r    <= cfg_wdata[15:0];
          tpmp_pkg::REG_STEP_COUNT:  step_count_r  <= cfg_wdata[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (in_acc && is_tick) begin
      pad_buttons_r  <= in_item.pad_buttons;
      pad_triggers_r <= in_item.pad_triggers;
      pad_sticks_r   <= in_item.pad_sticks;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // ---- checks ----
  `TPMP_ASSERT_RST(a_reset_quiet, !rst_n |=> (!out_strobe_r && !busy), "not quiet after reset")
  `TPMP_ASSERT(a_strobe_src, out_strobe_r |-> $past(tick_pass || scan_end), "stray result beat")
  `TPMP_ASSERT(a_play_scan, out_strobe_r && out_item_r.playing |-> $past(busy), "unscanned play")
  `TPMP_ASSERT(a_cfg_stops, cfg_we |=> !active_r, "config write did not stop playback")

endmodule

`default_nettype wire
